/* sv/rpi_pkg.sv */
// Shared constants and register codes for the ray/plane intersection block.
// No dependencies.
package rpi_pkg;

	localparam int NORMAL_BITS = 18;
	localparam int NORMAL_FRAC = 16;
	localparam int EPS_BITS    = 16;
	localparam int CFG_IDX_W   = 3;

	localparam logic signed [NORMAL_BITS-1:0] NORMAL_ONE = NORMAL_BITS'(1 << NORMAL_FRAC);
	localparam logic [EPS_BITS-1:0]           EPS_RESET  = EPS_BITS'(7);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_X  = 3'd0,
		REG_POINT_Y  = 3'd1,
		REG_POINT_Z  = 3'd2,
		REG_NORMAL_X = 3'd3,
		REG_NORMAL_Y = 3'd4,
		REG_NORMAL_Z = 3'd5,
		REG_EPSILON  = 3'd6
	} cfg_reg_t;

endpackage

/* sv/rpi_ray_if.sv */
// Ray channel: valid/ready handshake with origin and direction payload.
// No dependencies.
interface rpi_ray_if #(parameter int COORD_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] ray_origin_x;
	logic signed [COORD_BITS-1:0] ray_origin_y;
	logic signed [COORD_BITS-1:0] ray_origin_z;
	logic signed [COORD_BITS-1:0] ray_dir_x;
	logic signed [COORD_BITS-1:0] ray_dir_y;
	logic signed [COORD_BITS-1:0] ray_dir_z;

	modport source (output valid, ray_origin_x, ray_origin_y, ray_origin_z,
		ray_dir_x, ray_dir_y, ray_dir_z, input ready);
	modport sink (input valid, ray_origin_x, ray_origin_y, ray_origin_z,
		ray_dir_x, ray_dir_y, ray_dir_z, output ready);
endinterface

/* sv/rpi_hit_if.sv */
// Hit channel: valid/ready handshake with intersection point and flags.
// No dependencies.
interface rpi_hit_if #(parameter int COORD_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] hit_x;
	logic signed [COORD_BITS-1:0] hit_y;
	logic signed [COORD_BITS-1:0] hit_z;
	logic                         hit_valid;
	logic                         saturated;

	modport source (output valid, hit_x, hit_y, hit_z, hit_valid, saturated, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, hit_valid, saturated, output ready);
endinterface

/* sv/ray_plane_intersection.sv */
// Ray/plane intersection, fully pipelined with a bit-per-stage restoring divider.
// Depends on rpi_pkg, rpi_ray_if and rpi_hit_if.
//
//   channel  | kind           | moves
//   ray      | valid/ready in | origin xyz, direction xyz
//   hit      | valid/ready out| hit xyz, hit_valid, saturated
//   cfg      | write only     | cfg_we, cfg_index, cfg_data
//
// One ray is accepted per cycle while hit is not stalled; the restoring divider
// resolves one quotient bit per stage.
// Reset clears valid bits and loads the register defaults; payload is not reset.
// A stall on hit freezes every stage together; ray.ready follows it.
module ray_plane_intersection #(
	parameter int COORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rpi_ray_if.sink                ray,
	rpi_hit_if.source              hit,
	input  logic                   cfg_we,
	input  logic [rpi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [((COORD_BITS > rpi_pkg::NORMAL_BITS) ? COORD_BITS
		: rpi_pkg::NORMAL_BITS)-1:0] cfg_data
);
	import rpi_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int NB   = NORMAL_BITS;
	localparam int PWD  = CW + NB;
	localparam int PWN  = CW + 1 + NB;
	localparam int DW   = PWD + 2;
	localparam int NW   = PWN + 2;
	localparam int NL   = NW / 2;
	localparam int DL   = CW / 2;
	localparam int NUMW = NW + CW + 1;
	localparam int QB   = CW + 1;
	localparam int HW   = NUMW - QB;
	localparam int XW   = (HW > DW) ? HW : DW;
	localparam int RW   = DW + 1;
	localparam int SW   = CW + 3;

	localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

	typedef struct packed {
		logic [2:0][CW-1:0] org;
		logic [2:0]         neg;
		logic [2:0]         ovf;
		logic               miss;
		logic [DW-1:0]      dm;
	} side_t;

	// configuration
	logic signed [CW-1:0] pt_q [3];
	logic signed [NB-1:0] nrm_q [3];
	logic [EPS_BITS-1:0]  eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q[0]  <= '0;
			pt_q[1]  <= '0;
			pt_q[2]  <= '0;
			nrm_q[0] <= '0;
			nrm_q[1] <= NORMAL_ONE;
			nrm_q[2] <= '0;
			eps_q    <= EPS_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POINT_X:  pt_q[0]  <= cfg_data[CW-1:0];
				REG_POINT_Y:  pt_q[1]  <= cfg_data[CW-1:0];
				REG_POINT_Z:  pt_q[2]  <= cfg_data[CW-1:0];
				REG_NORMAL_X: nrm_q[0] <= cfg_data[NB-1:0];
				REG_NORMAL_Y: nrm_q[1] <= cfg_data[NB-1:0];
				REG_NORMAL_Z: nrm_q[2] <= cfg_data[NB-1:0];
				REG_EPSILON:  eps_q    <= cfg_data[EPS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// flow control: every stage advances together
	logic adv;
	logic hit_v_q;
	logic [7+QB:1] vld_s;

	assign adv       = !hit_v_q || hit.ready;
	assign ray.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			hit_v_q <= 1'b0;
		end else if (adv) begin
			vld_s   <= {vld_s[6+QB:1], ray.valid};
			hit_v_q <= vld_s[7+QB];
		end
	end

	logic signed [CW-1:0] org_in [3];
	logic signed [CW-1:0] dir_in [3];

	assign org_in[0] = ray.ray_origin_x;
	assign org_in[1] = ray.ray_origin_y;
	assign org_in[2] = ray.ray_origin_z;
	assign dir_in[0] = ray.ray_dir_x;
	assign dir_in[1] = ray.ray_dir_y;
	assign dir_in[2] = ray.ray_dir_z;

	// stage registers
	logic signed [PWD-1:0] pd_s1 [3];
	logic signed [PWN-1:0] pn_s1 [3];
	logic signed [CW-1:0]  org_s1 [3], dir_s1 [3];
	logic signed [DW-1:0]  d_s2;
	logic signed [NW-1:0]  num_s2;
	logic signed [CW-1:0]  org_s2 [3], dir_s2 [3];
	logic [DW-1:0]         dm_s3;
	logic                  miss_s3;
	logic [NW-1:0]         anum_s3;
	logic [CW-1:0]         adir_s3 [3];
	logic [2:0]            neg_s3;
	logic signed [CW-1:0]  org_s3 [3];
	logic [NL+DL-1:0]      ll_s4 [3];
	logic [NL+CW-DL-1:0]   lh_s4 [3];
	logic [NW-NL+DL-1:0]   hl_s4 [3];
	logic [NW-NL+CW-DL-1:0] hh_s4 [3];
	logic [DW-1:0]         dm_s4, dm_s5, dm_s6;
	logic                  miss_s4, miss_s5, miss_s6;
	logic [2:0]            neg_s4, neg_s5, neg_s6;
	logic signed [CW-1:0]  org_s4 [3], org_s5 [3], org_s6 [3];
	logic [NUMW-1:0]       a_s5 [3], b_s5 [3];
	logic [NUMW-1:0]       n_s6 [3];

	// side/rem/low/quo_s7[j] is pipeline stage 7 + j
	side_t           side_s7 [QB+1];
	logic [DW-1:0]   rem_s7  [QB+1][3];
	logic [QB-1:0]   low_s7  [QB+1][3];
	logic [QB-1:0]   quo_s7  [QB+1][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: products against the normal
			for (int k = 0; k < 3; k++) begin
				pd_s1[k]  <= PWD'(dir_in[k]) * PWD'(nrm_q[k]);
				pn_s1[k]  <= PWN'((CW+1)'(org_in[k]) - (CW+1)'(pt_q[k])) * PWN'(nrm_q[k]);
				org_s1[k] <= org_in[k];
				dir_s1[k] <= dir_in[k];
			end
			// stage 2: dot products
			d_s2   <= -(DW'(pd_s1[0]) + DW'(pd_s1[1]) + DW'(pd_s1[2]));
			num_s2 <= NW'(pn_s1[0]) + NW'(pn_s1[1]) + NW'(pn_s1[2]);
			org_s2 <= org_s1;
			dir_s2 <= dir_s1;
			// stage 3: magnitudes, signs and parallel test
			dm_s3   <= (d_s2 < 0) ? DW'(-d_s2) : DW'(d_s2);
			miss_s3 <= (d_s2 == '0) || (((d_s2 < 0) ? DW'(-d_s2) : DW'(d_s2))
				< DW'({eps_q, {NORMAL_FRAC{1'b0}}}));
			anum_s3 <= (num_s2 < 0) ? NW'(-num_s2) : NW'(num_s2);
			for (int k = 0; k < 3; k++) begin
				adir_s3[k] <= dir_s2[k][CW-1] ? CW'(-dir_s2[k]) : CW'(dir_s2[k]);
				neg_s3[k]  <= num_s2[NW-1] ^ dir_s2[k][CW-1] ^ d_s2[DW-1];
			end
			org_s3 <= org_s2;
			// stage 4: partial products of |num| * |dir|
			for (int k = 0; k < 3; k++) begin
				ll_s4[k] <= (NL+DL)'(anum_s3[NL-1:0]) * (NL+DL)'(adir_s3[k][DL-1:0]);
				lh_s4[k] <= (NL+CW-DL)'(anum_s3[NL-1:0]) * (NL+CW-DL)'(adir_s3[k][CW-1:DL]);
				hl_s4[k] <= (NW-NL+DL)'(anum_s3[NW-1:NL]) * (NW-NL+DL)'(adir_s3[k][DL-1:0]);
				hh_s4[k] <= (NW-NL+CW-DL)'(anum_s3[NW-1:NL])
					* (NW-NL+CW-DL)'(adir_s3[k][CW-1:DL]);
			end
			dm_s4   <= dm_s3;
			miss_s4 <= miss_s3;
			neg_s4  <= neg_s3;
			org_s4  <= org_s3;
			// stage 5: fold partial products, add half divisor for rounding
			for (int k = 0; k < 3; k++) begin
				a_s5[k] <= NUMW'(ll_s4[k]) + (NUMW'(lh_s4[k]) << DL) + NUMW'(dm_s4 >> 1);
				b_s5[k] <= NUMW'(hl_s4[k]) + (NUMW'(hh_s4[k]) << DL);
			end
			dm_s5   <= dm_s4;
			miss_s5 <= miss_s4;
			neg_s5  <= neg_s4;
			org_s5  <= org_s4;
			// stage 6: rounded dividend
			for (int k = 0; k < 3; k++)
				n_s6[k] <= a_s5[k] + (b_s5[k] << NL);
			dm_s6   <= dm_s5;
			miss_s6 <= miss_s5;
			neg_s6  <= neg_s5;
			org_s6  <= org_s5;
			// stage 7: quotients that cannot fit saturate anyway; flag them
			for (int k = 0; k < 3; k++) begin
				side_s7[0].org[k] <= org_s6[k];
				side_s7[0].ovf[k] <= XW'(n_s6[k][NUMW-1:QB]) >= XW'(dm_s6);
				rem_s7[0][k]      <= DW'(n_s6[k][NUMW-1:QB]);
				low_s7[0][k]      <= n_s6[k][QB-1:0];
				quo_s7[0][k]      <= '0;
			end
			side_s7[0].neg  <= neg_s6;
			side_s7[0].miss <= miss_s6;
			side_s7[0].dm   <= dm_s6;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_div
		for (genvar k = 0; k < 3; k++) begin : g_lane
			logic [RW-1:0] trial;
			logic          fits;

			assign trial = {rem_s7[j][k], low_s7[j][k][QB-1]};
			assign fits  = trial >= RW'(side_s7[j].dm);

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s7[j+1][k] <= fits ? DW'(trial - RW'(side_s7[j].dm)) : DW'(trial);
					low_s7[j+1][k] <= low_s7[j][k] << 1;
					quo_s7[j+1][k] <= {quo_s7[j][k][QB-2:0], fits};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				side_s7[j+1] <= side_s7[j];
		end
	end

	// output stage: apply sign, add origin, clamp
	logic signed [CW-1:0] res [3];
	logic [2:0]           sat;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [SW-1:0] q;
			logic signed [SW-1:0] v;
			q = signed'(SW'(quo_s7[QB][k]));
			v = SW'(signed'(side_s7[QB].org[k])) + (side_s7[QB].neg[k] ? -q : q);
			sat[k] = 1'b0;
			if (side_s7[QB].ovf[k]) begin
				sat[k] = 1'b1;
				res[k] = side_s7[QB].neg[k] ? CW'(MINV) : CW'(MAXV);
			end else if (v > MAXV) begin
				sat[k] = 1'b1;
				res[k] = CW'(MAXV);
			end else if (v < MINV) begin
				sat[k] = 1'b1;
				res[k] = CW'(MINV);
			end else begin
				res[k] = CW'(v);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s7[QB].miss) begin
				hit.hit_x     <= '0;
				hit.hit_y     <= '0;
				hit.hit_z     <= '0;
				hit.hit_valid <= 1'b0;
				hit.saturated <= 1'b0;
			end else begin
				hit.hit_x     <= res[0];
				hit.hit_y     <= res[1];
				hit.hit_z     <= res[2];
				hit.hit_valid <= 1'b1;
				hit.saturated <= |sat;
			end
		end
	end

	assign hit.valid = hit_v_q;

endmodule
